// File: hdl/nrb_pkg.sv
// shared types and constants for the nth-root bisection block
// no dependencies; imported by every module of the block
package nrb_pkg;

    // value format: unsigned q16.16
    localparam int FRAC_BITS = 16;
    localparam int VAL_BITS  = 32;
    localparam int PROD_BITS = 2 * VAL_BITS;
    localparam int DEG_BITS  = 4;

    localparam logic [VAL_BITS-1:0] ONE_FX = VAL_BITS'(1) << FRAC_BITS;

    // controller states, one-hot
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_TEST = 4'b0010,
        S_MUL  = 4'b0100,
        S_CHK  = 4'b1000
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic load;       // take a new input beat
        logic step_init;  // form midpoint, reset power and count
        logic mul;        // register power * midpoint
        logic chk;        // evaluate product, move bracket when done
        logic out_load;   // copy bracket into output register
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic span_done;  // bracket at most one lsb wide
        logic sat;        // current product overflows
        logic last;       // current product is the final power
    } t_status;

endpackage

// File: hdl/nrb_dp.sv
// datapath of the nth-root bisection: bracket, midpoint, shared multiplier
// depends on nrb_pkg; driven by nrb_ctrl through command and status structs
module nrb_dp #(
    parameter int MAX_DEGREE = 15
) (
    input  logic                         i_clk,
    input  nrb_pkg::t_cmd                i_cmd,
    input  logic [nrb_pkg::VAL_BITS-1:0] i_radicand,
    input  logic [nrb_pkg::DEG_BITS-1:0] i_degree,
    output nrb_pkg::t_status             o_status,
    output logic [nrb_pkg::VAL_BITS-1:0] o_root_low,
    output logic [nrb_pkg::VAL_BITS-1:0] o_root_high
);
    import nrb_pkg::*;

    logic [VAL_BITS-1:0]  r_x, r_lo, r_hi, r_mid, r_pow;
    logic [VAL_BITS-1:0]  r_out_lo, r_out_hi;
    logic [PROD_BITS-1:0] r_prod;
    logic [DEG_BITS-1:0]  r_deg, r_cnt;

    logic [DEG_BITS-1:0]  deg_clamped;
    logic [DEG_BITS-1:0]  cnt_inc;
    logic [VAL_BITS:0]    mid_sum;
    logic [VAL_BITS-1:0]  span;
    logic [VAL_BITS-1:0]  new_pow;
    logic                 below;

    // degree zero acts as one, large degrees saturate
    always_comb begin
        if (i_degree == '0) begin
            deg_clamped = DEG_BITS'(1);
        end else if (int'(i_degree) > MAX_DEGREE) begin
            deg_clamped = DEG_BITS'(MAX_DEGREE);
        end else begin
            deg_clamped = i_degree;
        end
    end

    // status decode
    assign span    = r_hi - r_lo;
    assign mid_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign cnt_inc = r_cnt + DEG_BITS'(1);
    assign new_pow = r_prod[FRAC_BITS +: VAL_BITS];
    assign below   = new_pow < r_x;

    assign o_status.span_done = span <= VAL_BITS'(1);
    assign o_status.sat       = |r_prod[PROD_BITS-1:FRAC_BITS+VAL_BITS];
    assign o_status.last      = cnt_inc == r_deg;

    // bracket and power registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x   <= i_radicand;
            r_deg <= deg_clamped;
            if (i_radicand < ONE_FX) begin
                r_lo <= i_radicand;
                r_hi <= ONE_FX;
            end else begin
                r_lo <= ONE_FX;
                r_hi <= i_radicand;
            end
        end
        if (i_cmd.step_init) begin
            r_mid <= mid_sum[VAL_BITS:1];
            r_pow <= ONE_FX;
            r_cnt <= '0;
        end
        if (i_cmd.mul) begin
            r_prod <= PROD_BITS'(r_pow) * PROD_BITS'(r_mid);
        end
        if (i_cmd.chk) begin
            r_pow <= new_pow;
            r_cnt <= cnt_inc;
            if (o_status.sat) begin
                r_hi <= r_mid;
            end else if (o_status.last) begin
                if (below) begin
                    r_lo <= r_mid;
                end else begin
                    r_hi <= r_mid;
                end
            end
        end
        if (i_cmd.out_load) begin
            r_out_lo <= r_lo;
            r_out_hi <= r_hi;
        end
    end

    assign o_root_low  = r_out_lo;
    assign o_root_high = r_out_hi;

endmodule

// File: hdl/nrb_ctrl.sv
// controller of the nth-root bisection: sequences steps and multiplies
// depends on nrb_pkg; commands nrb_dp and owns both handshakes
module nrb_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    output logic             o_valid,
    input  logic             i_ready,
    input  nrb_pkg::t_status i_status,
    output nrb_pkg::t_cmd    o_cmd
);
    import nrb_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_ready;
    assign o_ready  = r_state == S_IDLE;
    assign o_valid  = r_out_valid;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_TEST;
                end
            end
            S_TEST: begin
                if (i_status.span_done) begin
                    if (out_free) begin
                        o_cmd.out_load = 1'b1;
                        n_state        = S_IDLE;
                    end
                end else begin
                    o_cmd.step_init = 1'b1;
                    n_state         = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_CHK;
            end
            S_CHK: begin
                o_cmd.chk = 1'b1;
                if (i_status.sat || i_status.last) begin
                    n_state = S_TEST;
                end else begin
                    n_state = S_MUL;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // output beat held until taken
    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// File: hdl/nth_root_bisection.sv
// each bisection step forms the midpoint, raises it to the degree d by repeated multiplies
// (stopping early when the power overflows) and moves the bracket; up to about 32 steps
// the single 32x32 multiplier, shared by all these multiplies, sets the rate
// a new input beat is taken only in idle, once the search before it has ended; the next beat
// is taken while a result waits
// reset: synchronous active low, clears controller state and output valid
// top level: instantiates nrb_ctrl and nrb_dp, uses nrb_pkg
module nth_root_bisection #(
    parameter int MAX_DEGREE = 15
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [nrb_pkg::VAL_BITS-1:0] i_radicand,
    input  logic [nrb_pkg::DEG_BITS-1:0] i_degree,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [nrb_pkg::VAL_BITS-1:0] o_root_low,
    output logic [nrb_pkg::VAL_BITS-1:0] o_root_high
);
    import nrb_pkg::*;

    t_cmd    cmd;
    t_status status;

    // sequencing
    nrb_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // arithmetic
    nrb_dp #(
        .MAX_DEGREE (MAX_DEGREE)
    ) u_dp (
        .i_clk       (i_clk),
        .i_cmd       (cmd),
        .i_radicand  (i_radicand),
        .i_degree    (i_degree),
        .o_status    (status),
        .o_root_low  (o_root_low),
        .o_root_high (o_root_high)
    );

endmodule

// File: hdl/nrb_check.sv
// port-level checks for the nth-root bisection block
// depends on nrb_pkg; bound to nth_root_bisection below
module nrb_check (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_valid,
    input logic                         o_ready,
    input logic                         o_valid,
    input logic                         i_ready,
    input logic [nrb_pkg::VAL_BITS-1:0] o_root_low,
    input logic [nrb_pkg::VAL_BITS-1:0] o_root_high
);
    import nrb_pkg::*;

    // stalled output beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_root_low) && $stable(o_root_high))
        else $error("output beat changed while stalled");

    // result bracket is ordered and at most one lsb wide
    a_bracket: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_root_high >= o_root_low) &&
                    ((o_root_high - o_root_low) <= VAL_BITS'(1)))
        else $error("result bracket too wide or reversed");

    // an accepted beat makes the block busy
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("ready stayed high after input beat");

    // no new result is flagged right after an input beat is taken on an empty output
    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && !o_valid |=> !o_valid)
        else $error("result appeared right after input beat");

endmodule

bind nth_root_bisection nrb_check u_nrb_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_ready     (o_ready),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_root_low  (o_root_low),
    .o_root_high (o_root_high)
);
